// ===== src/rfd_pkg.sv =====
// Shared types, constants and helper functions for the RGB565 frame downscaler.
// No dependencies; every module of the block imports this package.
package rfd_pkg;

    localparam int SRC_WIDTH       = 256;
    localparam int SRC_HEIGHT      = 224;
    localparam int OUT_SIDE        = 128;
    localparam int COL_W           = $clog2(SRC_WIDTH);
    localparam int ROW_W           = $clog2(SRC_HEIGHT);
    localparam int OUT_W           = $clog2(OUT_SIDE);
    localparam int FILL_CROP       = 16;
    localparam int FILL_SPAN       = 224;
    localparam int FIT_TOP         = 8;
    localparam int FIT_ROWS        = 112;
    localparam int LETTER_ROW_LOW  = 0;
    localparam int LETTER_ROW_HIGH = 222;
    localparam int LETTER_BURST    = 4;
    localparam int BURST_W         = $clog2(LETTER_BURST);

    typedef struct packed {
        logic [15:0] pixel;
        logic        frame_start;
    } t_in_beat;

    typedef struct packed {
        logic [OUT_W-1:0] out_x;
        logic [OUT_W-1:0] out_y;
        logic [15:0]      color;
        logic             run_last;
    } t_out_beat;

    // Everything stage two needs about one accepted pixel
    typedef struct packed {
        logic [15:0]      pixel;
        logic [15:0]      left;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             mode;
    } t_stage;

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_PIXEL,
        KIND_LETTER
    } t_kind;

    localparam logic SCALE_CROP      = 1'b0;
    localparam logic SCALE_LETTERBOX = 1'b1;

    // Entry s: {hit, i} where s == floor(i*7/4) for some image index i
    typedef logic [SRC_WIDTH-1:0][OUT_W:0] t_fill_tab;

    function automatic t_fill_tab build_fill_tab();
        t_fill_tab tab;
        int        s;
        tab = '0;
        for (int i = 0; i < OUT_SIDE; i++) begin
            s = (i * 7) >> 2;
            tab[s] = {1'b1, OUT_W'(i)};
        end
        return tab;
    endfunction

    localparam t_fill_tab FILL_TAB = build_fill_tab();

    // 2x2 box average per channel, truncated
    function automatic logic [15:0] box_avg(input logic [15:0] a, input logic [15:0] b,
                                            input logic [15:0] c, input logic [15:0] d);
        logic [6:0] r;
        logic [7:0] g;
        logic [6:0] bl;
        r  = 7'(a[15:11]) + 7'(b[15:11]) + 7'(c[15:11]) + 7'(d[15:11]);
        g  = 8'(a[10:5]) + 8'(b[10:5]) + 8'(c[10:5]) + 8'(d[10:5]);
        bl = 7'(a[4:0]) + 7'(b[4:0]) + 7'(c[4:0]) + 7'(d[4:0]);
        return {r[6:2], g[7:2], bl[6:2]};
    endfunction

endpackage

// ===== src/rfd_line_ram.sv =====
// One-row line store: synchronous RAM, read-first, with registered read data.
// Depends on rfd_pkg.
module rfd_line_ram
    import rfd_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [COL_W-1:0] i_addr,
    input  logic [15:0]      i_wdata,
    output logic [15:0]      o_rdata
);

    logic [15:0] r_mem [SRC_WIDTH];
    logic [15:0] r_rdata;

    // Same address read and written: old contents come out
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rdata        <= r_mem[i_addr];
            r_mem[i_addr]  <= i_wdata;
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/rfd_emit.sv =====
// Second stage: box average, destination mapping, letterbox burst sequencer
// and output register. Depends on rfd_pkg.
module rfd_emit
    import rfd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_load,
    input  t_stage    i_stage,
    input  logic [15:0] i_up,
    output logic      o_free,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_beat o_out
);

    logic               r_b_valid;
    t_stage             r_b;
    logic [15:0]        r_upleft;
    logic [BURST_W-1:0] r_j;
    logic               r_o_valid;
    t_out_beat          r_o;

    logic               n_b_valid;
    logic [15:0]        n_upleft;
    logic [BURST_W-1:0] n_j;
    logic               n_o_valid;
    t_out_beat          n_o;

    t_kind            kind;
    logic             out_free;
    logic             b_done;
    logic             letter_row;
    logic             fill_hit;
    logic [COL_W-1:0] fill_col;
    logic [ROW_W-1:0] fill_row;
    logic [OUT_W:0]   tab_x;
    logic [OUT_W:0]   tab_y;
    logic [15:0]      avg;
    logic [OUT_W-1:0] letter_base;

    assign fill_col = r_b.col - COL_W'(FILL_CROP + 1);
    assign fill_row = r_b.row - ROW_W'(1);
    assign tab_x    = FILL_TAB[fill_col];
    assign tab_y    = FILL_TAB[fill_row];
    assign fill_hit = (r_b.row >= ROW_W'(1)) && (r_b.col >= COL_W'(FILL_CROP + 1))
                   && ({1'b0, r_b.col} < (COL_W+1)'(FILL_CROP + FILL_SPAN))
                   && tab_x[OUT_W] && tab_y[OUT_W];
    assign letter_row  = (r_b.row == ROW_W'(LETTER_ROW_LOW))
                      || (r_b.row == ROW_W'(LETTER_ROW_HIGH));
    assign letter_base = (r_b.row == ROW_W'(LETTER_ROW_LOW)) ? '0
                                                             : OUT_W'(FIT_TOP + FIT_ROWS);
    assign avg      = box_avg(r_upleft, i_up, r_b.left, r_b.pixel);
    assign out_free = !r_o_valid || i_ready;

    always_comb begin
        if (r_b.mode == SCALE_LETTERBOX) begin
            if (letter_row) begin
                kind = KIND_LETTER;
            end else if (r_b.row[0] && r_b.col[0]) begin
                kind = KIND_PIXEL;
            end else begin
                kind = KIND_NONE;
            end
        end else begin
            kind = fill_hit ? KIND_PIXEL : KIND_NONE;
        end
    end

    always_comb begin
        n_o       = r_o;
        n_o_valid = r_o_valid && !i_ready;
        n_j       = r_j;
        b_done    = 1'b0;
        if (r_b_valid) begin
            case (kind)
                KIND_NONE: begin
                    b_done = 1'b1;
                end
                KIND_PIXEL: begin
                    if (out_free) begin
                        b_done    = 1'b1;
                        n_o_valid = 1'b1;
                        n_o.color    = avg;
                        n_o.run_last = 1'b1;
                        if (r_b.mode == SCALE_LETTERBOX) begin
                            n_o.out_x = r_b.col[COL_W-1:1];
                            n_o.out_y = OUT_W'(FIT_TOP) + OUT_W'(r_b.row[ROW_W-1:1]);
                        end else begin
                            n_o.out_x = tab_x[OUT_W-1:0];
                            n_o.out_y = tab_y[OUT_W-1:0];
                        end
                    end
                end
                KIND_LETTER: begin
                    if (out_free) begin
                        n_o_valid    = 1'b1;
                        // k = col*4 + j: x = k mod 128, y = base + k / 128
                        n_o.out_x    = {r_b.col[OUT_W-BURST_W-1:0], r_j};
                        n_o.out_y    = letter_base + OUT_W'(r_b.col[COL_W-1:OUT_W-BURST_W]);
                        n_o.color    = '0;
                        n_o.run_last = &r_j;
                        n_j          = r_j + BURST_W'(1);
                        b_done       = &r_j;
                    end
                end
                default: begin
                    b_done = 1'b1;
                end
            endcase
        end
        o_free    = !r_b_valid || b_done;
        n_b_valid = i_load || (r_b_valid && !b_done);
        n_upleft  = (r_b_valid && b_done) ? i_up : r_upleft;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_o_valid <= 1'b0;
            r_j       <= '0;
            r_upleft  <= '0;
        end else begin
            r_b_valid <= n_b_valid;
            r_o_valid <= n_o_valid;
            r_j       <= n_j;
            r_upleft  <= n_upleft;
        end
    end

    always_ff @(posedge i_clk) begin
        r_o <= n_o;
        if (i_load) begin
            r_b <= i_stage;
        end
    end

    assign o_valid = r_o_valid;
    assign o_out   = r_o;

endmodule

// ===== src/rgb565_frame_downscaler_core.sv =====
// Each accepted pixel is held in the stage-two register; its result goes to the output register.
// One pixel per cycle while the output is not stalled; a letterbox-row pixel in fit mode
// makes four black writes, one at a time through the single output register.
// Line store is a one-port read-first RAM, read and written in the accept cycle.
// Reset (synchronous, active low) clears counters, the left and up-left pixel registers and mode;
// the line store is not cleared.
module rgb565_frame_downscaler_core
    import rfd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_beat  i_in,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_beat o_out,
    input  logic      i_cfg_we,
    input  logic      i_cfg_data
);

    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;
    logic [15:0]      r_left;
    logic             r_mode;

    logic [COL_W-1:0] n_col;
    logic [ROW_W-1:0] n_row;
    logic [COL_W-1:0] cur_col;
    logic [ROW_W-1:0] cur_row;
    logic             accept;
    logic             emit_free;
    logic [15:0]      up;
    t_stage           stage;

    assign accept  = i_valid && emit_free;
    assign o_ready = emit_free;

    assign cur_col = i_in.frame_start ? '0 : r_col;
    assign cur_row = i_in.frame_start ? '0 : r_row;

    always_comb begin
        n_col = cur_col + COL_W'(1);
        n_row = cur_row;
        if (&cur_col) begin
            n_row = (cur_row == ROW_W'(SRC_HEIGHT - 1)) ? '0 : cur_row + ROW_W'(1);
        end
        stage.pixel = i_in.pixel;
        stage.left  = r_left;
        stage.col   = cur_col;
        stage.row   = cur_row;
        stage.mode  = r_mode;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_left <= '0;
            r_mode <= SCALE_CROP;
        end else begin
            if (accept) begin
                r_col  <= n_col;
                r_row  <= n_row;
                r_left <= i_in.pixel;
            end
            if (i_cfg_we) begin
                r_mode <= i_cfg_data;
            end
        end
    end

    rfd_line_ram u_line_ram (
        .i_clk   (i_clk),
        .i_en    (accept),
        .i_addr  (cur_col),
        .i_wdata (i_in.pixel),
        .o_rdata (up)
    );

    rfd_emit u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (accept),
        .i_stage (stage),
        .i_up    (up),
        .o_free  (emit_free),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_out   (o_out)
    );

endmodule
